/* sv/tbpt_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, the table row layout and the controller interface types.
package tbpt_pkg;

   localparam int BUCKETS = 2048;
   localparam int ADDR_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   localparam int IDX_W  = 11;
   localparam int TIME_W = 64;
   localparam int LEN_W  = 16;
   localparam int RATE_W = 32;
   localparam int COST_W = LEN_W + RATE_W;

   typedef enum logic {
      FUNC_POLICE = 1'b0,
      FUNC_LOAD   = 1'b1
   } func_type;

   // One table entry as it is kept in the RAM.
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] burst;
      logic [RATE_W-1:0] rate;
      logic [TIME_W-1:0] allowance;
      logic [TIME_W-1:0] last_time;
      logic [TIME_W-1:0] tokens;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic clear;    // write one zero row of the reset sweep
      logic capture;  // take in the accepted transaction
      logic lookup;   // evaluate the row read for the captured index
      logic refill;   // add elapsed time to the tokens, cap at the burst
      logic settle;   // charge the packet cost against the tokens
      logic commit;   // write the row back and post the result
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic rsp_free;
   } ctl_status_type;

endpackage

/* sv/token_bucket_policer_table.sv */
`timescale 1ns / 1ps
// Per-flow token bucket policer table built around one table RAM with a registered read
// port and a separate write port. After reset the block sweeps the table once, one entry
// per cycle, over all 2048 entries (BUCKETS), and stalls requests meanwhile. A transaction then
// occupies the block for the RAM read in the cycle of acceptance, three
// arithmetic steps (lookup with the cost multiply, saturating refill capped at the burst,
// cost charge) and a write-back that posts the result. No new request is taken until
// the previous one has been written back; the read-modify-write of the one table RAM
// sets this limit. The write-back waits as long as an earlier result is still stalled in
// the output register, and a new request is accepted in the cycle after the write-back
// even while that result waits. A load sets the burst, per-byte cost and allowance and
// clears the last-update time; a packet on an unloaded entry passes with hit low.
module token_bucket_policer_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [tbpt_pkg::IDX_W-1:0]    req_bucket_index,
   input  logic [tbpt_pkg::TIME_W-1:0]   req_now_ns,
   input  logic [tbpt_pkg::LEN_W-1:0]    req_packet_length,
   input  logic [tbpt_pkg::TIME_W-1:0]   req_entry_burst,
   input  logic [tbpt_pkg::RATE_W-1:0]   req_entry_cost_rate,
   input  logic [tbpt_pkg::TIME_W-1:0]   req_entry_allowance,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_drop,
   output logic                          rsp_hit
);
   import tbpt_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   tbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tbpt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_func),
      .req_bucket_index    (req_bucket_index),
      .req_now_ns          (req_now_ns),
      .req_packet_length   (req_packet_length),
      .req_entry_burst     (req_entry_burst),
      .req_entry_cost_rate (req_entry_cost_rate),
      .req_entry_allowance (req_entry_allowance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drop            (rsp_drop),
      .rsp_hit             (rsp_hit)
   );

endmodule

/* sv/tbpt_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module tbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tbpt_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: reset sweep, then one transaction at a time.
module tbpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tbpt_pkg::ctl_status_type status,
   output tbpt_pkg::ctl_cmd_type    cmd
);
   import tbpt_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_REFILL = 6'b001000,
      ST_SETTLE = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_REFILL;
         end
         ST_REFILL: begin
            cmd.refill = 1'b1;
            state_in   = ST_SETTLE;
         end
         ST_SETTLE: begin
            cmd.settle = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            // The result register must be free before the row is written back.
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("transaction accepted during the reset sweep");

   a_accept_goes_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted transaction did not start a lookup");

   a_commit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.rsp_free)
      else $error("commit while the result register is occupied");

endmodule

/* sv/tbpt_datapath.sv */
`timescale 1ns / 1ps
// Datapath: transaction capture, bucket arithmetic, table RAM and result register.
module tbpt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tbpt_pkg::ctl_cmd_type          cmd,
   output tbpt_pkg::ctl_status_type       status,
   input  logic                          req_func,
   input  logic [tbpt_pkg::IDX_W-1:0]    req_bucket_index,
   input  logic [tbpt_pkg::TIME_W-1:0]   req_now_ns,
   input  logic [tbpt_pkg::LEN_W-1:0]    req_packet_length,
   input  logic [tbpt_pkg::TIME_W-1:0]   req_entry_burst,
   input  logic [tbpt_pkg::RATE_W-1:0]   req_entry_cost_rate,
   input  logic [tbpt_pkg::TIME_W-1:0]   req_entry_allowance,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_drop,
   output logic                          rsp_hit
);
   import tbpt_pkg::*;

   // Captured transaction.
   logic               func_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               in_range_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [TIME_W-1:0]  ld_burst_ff;
   logic [RATE_W-1:0]  ld_rate_ff;
   logic [TIME_W-1:0]  ld_allow_ff;

   // Lookup results.
   row_type            row_ff;
   logic               hit_ff;
   logic [TIME_W-1:0]  tok0_ff;
   logic [TIME_W-1:0]  elapsed_ff;
   logic               short_ff;
   logic [TIME_W-1:0]  allow_ff;
   logic [TIME_W-1:0]  last_ff;
   logic [COST_W-1:0]  cost_ff;

   // Refill and settle results.
   logic [TIME_W-1:0]  tok1_ff;
   logic [TIME_W-1:0]  tok_final_ff;
   logic               pass_ff;

   // Reset sweep and result register.
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_drop_ff;
   logic               rsp_hit_ff;

   row_type            ram_rd;
   row_type            ram_wd;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_wa;
   logic [ADDR_W-1:0]  ram_ra;

   logic               first_use;
   logic [TIME_W:0]    refill_sum;
   logic [TIME_W-1:0]  refill_sat;
   logic [TIME_W-1:0]  cost_ext;
   logic               commit_we;
   row_type            commit_row;
   logic               commit_drop;

   // The read address follows the request port; the row of an accepted
   // transaction is therefore on the RAM output in the following cycle.
   assign ram_ra = ADDR_W'(req_bucket_index);

   tbpt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= req_func;
         addr_ff     <= ADDR_W'(req_bucket_index);
         in_range_ff <= (32'(req_bucket_index) < BUCKETS);
         now_ff      <= req_now_ns;
         len_ff      <= req_packet_length;
         ld_burst_ff <= req_entry_burst;
         ld_rate_ff  <= req_entry_cost_rate;
         ld_allow_ff <= req_entry_allowance;
      end
   end

   // A stored last-update time of zero marks the first use after a load.
   assign first_use = (ram_rd.last_time == '0);

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         row_ff     <= ram_rd;
         hit_ff     <= in_range_ff && ram_rd.valid;
         tok0_ff    <= first_use ? ram_rd.burst : ram_rd.tokens;
         elapsed_ff <= first_use ? '0 : (now_ff - ram_rd.last_time);
         short_ff   <= (ram_rd.allowance < TIME_W'(len_ff));
         allow_ff   <= ram_rd.allowance - TIME_W'(len_ff);
         last_ff    <= first_use ? now_ff : ram_rd.last_time;
         cost_ff    <= COST_W'(len_ff) * COST_W'(ram_rd.rate);
      end
   end

   assign refill_sum = {1'b0, tok0_ff} + {1'b0, elapsed_ff};
   assign refill_sat = refill_sum[TIME_W] ? '1 : refill_sum[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.refill) begin
         tok1_ff <= (refill_sat > row_ff.burst) ? row_ff.burst : refill_sat;
      end
   end

   assign cost_ext = TIME_W'(cost_ff);

   always_ff @(posedge clock) begin
      if (cmd.settle) begin
         pass_ff      <= (tok1_ff >= cost_ext);
         tok_final_ff <= (tok1_ff >= cost_ext) ? (tok1_ff - cost_ext) : tok1_ff;
      end
   end

   always_comb begin
      commit_we   = 1'b0;
      commit_drop = 1'b0;
      commit_row  = row_ff;
      if (in_range_ff) begin
         if (func_ff == FUNC_LOAD) begin
            commit_we            = 1'b1;
            commit_row.valid     = 1'b1;
            commit_row.burst     = ld_burst_ff;
            commit_row.rate      = ld_rate_ff;
            commit_row.allowance = ld_allow_ff;
            commit_row.last_time = '0;
         end else if (hit_ff) begin
            commit_we = 1'b1;
            if (short_ff) begin
               // Only the first-use updates survive a short allowance.
               commit_drop          = 1'b1;
               commit_row.tokens    = tok0_ff;
               commit_row.last_time = last_ff;
            end else begin
               commit_drop          = !pass_ff;
               commit_row.tokens    = tok_final_ff;
               commit_row.last_time = now_ff;
               commit_row.allowance = allow_ff;
            end
         end
      end
   end

   assign ram_we = cmd.clear || (cmd.commit && commit_we);
   assign ram_wa = cmd.clear ? clr_addr_ff : addr_ff;
   assign ram_wd = cmd.clear ? row_type'('0) : commit_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign status.clear_done = (clr_addr_ff == ADDR_W'(BUCKETS - 1));
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_drop_ff <= commit_drop;
         rsp_hit_ff  <= hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drop  = rsp_drop_ff;
   assign rsp_hit   = rsp_hit_ff;

   a_write_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (cmd.clear || cmd.commit))
      else $error("table write outside the sweep or a commit");

   a_commit_posts_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not post a result");

   a_load_never_drops: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && func_ff == FUNC_LOAD) |=> !rsp_drop_ff)
      else $error("load transaction reported a drop");

endmodule

/* sim/token_bucket_policer_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the token bucket policer table, with its own bucket predictor.
module token_bucket_policer_table_tb;
   import tbpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 12000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 400;
   localparam int FLOW_COUNT     = 12;

   typedef struct {
      func_type           func;
      logic [IDX_W-1:0]   idx;
      logic [TIME_W-1:0]  now;
      logic [LEN_W-1:0]   len;
      logic [TIME_W-1:0]  burst;
      logic [RATE_W-1:0]  rate;
      logic [TIME_W-1:0]  allow;
   } policer_req_type;

   typedef struct {
      logic drop;
      logic hit;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = 1'b0;
   logic [IDX_W-1:0]    req_bucket_index = '0;
   logic [TIME_W-1:0]   req_now_ns = '0;
   logic [LEN_W-1:0]    req_packet_length = '0;
   logic [TIME_W-1:0]   req_entry_burst = '0;
   logic [RATE_W-1:0]   req_entry_cost_rate = '0;
   logic [TIME_W-1:0]   req_entry_allowance = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_drop;
   logic                rsp_hit;

   // Predicted table contents.
   bit                  flow_valid  [BUCKETS];
   logic [TIME_W-1:0]   flow_tokens [BUCKETS];
   logic [TIME_W-1:0]   flow_stamp  [BUCKETS];
   logic [TIME_W-1:0]   flow_allow  [BUCKETS];
   logic [TIME_W-1:0]   flow_burst  [BUCKETS];
   logic [RATE_W-1:0]   flow_rate   [BUCKETS];

   verdict_type         expected_verdicts [$];
   int                  mismatch_count = 0;
   int                  idle_cycles = 0;
   int                  hold_request = 0;
   bit                  tx_idle_en = 1'b0;
   bit                  rx_idle_en = 1'b0;
   logic [TIME_W-1:0]   flow_clock = 64'd1000;
   logic [IDX_W-1:0]    flow_ids [FLOW_COUNT];

   token_bucket_policer_table uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_bucket_index    (req_bucket_index),
      .req_now_ns          (req_now_ns),
      .req_packet_length   (req_packet_length),
      .req_entry_burst     (req_entry_burst),
      .req_entry_cost_rate (req_entry_cost_rate),
      .req_entry_allowance (req_entry_allowance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drop            (rsp_drop),
      .rsp_hit             (rsp_hit)
   );

   always #2 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly short gaps with an occasional long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic policer_req_type load_req(input logic [IDX_W-1:0] idx,
                                                input logic [TIME_W-1:0] burst,
                                                input logic [RATE_W-1:0] rate,
                                                input logic [TIME_W-1:0] allow);
      policer_req_type r;
      r.func  = FUNC_LOAD;
      r.idx   = idx;
      r.now   = rand64();
      r.len   = LEN_W'($urandom());
      r.burst = burst;
      r.rate  = rate;
      r.allow = allow;
      return r;
   endfunction

   function automatic policer_req_type packet_req(input logic [IDX_W-1:0] idx,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic [LEN_W-1:0] len);
      policer_req_type r;
      r.func  = FUNC_POLICE;
      r.idx   = idx;
      r.now   = now;
      r.len   = len;
      r.burst = rand64();
      r.rate  = $urandom();
      r.allow = rand64();
      return r;
   endfunction

   // Applies one transaction to the predicted table and returns its verdict.
   function automatic verdict_type predict_verdict(input policer_req_type r);
      verdict_type          v;
      logic [ADDR_W-1:0]    i;
      logic [TIME_W-1:0]    gap_ns;
      logic [TIME_W-1:0]    tok;
      logic [COST_W-1:0]    cost;
      i      = ADDR_W'(r.idx);
      v.hit  = flow_valid[i];
      v.drop = 1'b0;
      if (r.func == FUNC_LOAD) begin
         flow_burst[i] = r.burst;
         flow_rate[i]  = r.rate;
         flow_allow[i] = r.allow;
         flow_stamp[i] = '0;
         flow_valid[i] = 1'b1;
      end else if (v.hit) begin
         gap_ns = r.now - flow_stamp[i];
         // A stored time of zero marks a bucket that has not been used yet.
         if (flow_stamp[i] == '0) begin
            flow_tokens[i] = flow_burst[i];
            flow_stamp[i]  = r.now;
            gap_ns         = '0;
         end
         if (flow_allow[i] < TIME_W'(r.len)) begin
            v.drop = 1'b1;
         end else begin
            flow_allow[i] = flow_allow[i] - TIME_W'(r.len);
            tok = flow_tokens[i];
            if (tok > ~gap_ns) tok = '1;
            else tok = tok + gap_ns;
            if (tok > flow_burst[i]) tok = flow_burst[i];
            flow_stamp[i] = r.now;
            cost = COST_W'(r.len) * COST_W'(flow_rate[i]);
            if (tok >= TIME_W'(cost)) begin
               flow_tokens[i] = tok - TIME_W'(cost);
            end else begin
               flow_tokens[i] = tok;
               v.drop = 1'b1;
            end
         end
      end
      return v;
   endfunction

   // A well-formed transaction on one of the active flows, with time mostly moving forward.
   function automatic policer_req_type flow_item();
      policer_req_type   r;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] burst;
      logic [RATE_W-1:0] rate;
      logic [TIME_W-1:0] allow;
      logic [TIME_W-1:0] now;
      logic [LEN_W-1:0]  len;
      int                roll;
      idx  = flow_ids[$urandom_range(0, FLOW_COUNT-1)];
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         burst = ($urandom_range(0, 99) < 85) ? TIME_W'($urandom_range(0, 50000)) : rand64();
         rate  = ($urandom_range(0, 99) < 80) ? RATE_W'($urandom_range(0, 20)) : $urandom();
         roll  = $urandom_range(0, 99);
         if (roll < 70) allow = TIME_W'($urandom_range(0, 400000));
         else if (roll < 90) allow = rand64();
         else allow = TIME_W'($urandom_range(0, 3000));
         r = load_req(idx, burst, rate, allow);
      end else begin
         if (roll < 13) begin
            now = '0;
         end else if (roll < 16) begin
            now = flow_clock - TIME_W'($urandom_range(1, 100000));
         end else begin
            flow_clock = flow_clock + TIME_W'($urandom_range(0, 2500));
            now = flow_clock;
         end
         len = ($urandom_range(0, 99) < 80) ? LEN_W'($urandom_range(0, 1500)) : LEN_W'($urandom());
         r = packet_req(idx, now, len);
      end
      return r;
   endfunction

   // Offers one transaction and records its verdict once the block takes it.
   task automatic send_item(input policer_req_type r);
      int gap;
      gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= r.func;
      req_bucket_index    <= r.idx;
      req_now_ns          <= r.now;
      req_packet_length   <= r.len;
      req_entry_burst     <= r.burst;
      req_entry_cost_rate <= r.rate;
      req_entry_allowance <= r.allow;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_verdicts.push_back(predict_verdict(r));
   endtask

   task automatic test_misses_and_loads();
      send_item(packet_req('0, 64'd5, '1));
      send_item(packet_req('1, '1, '0));
      send_item(load_req('0, 64'd1000, 32'd1, '1));
      send_item(load_req('1, '1, '1, 64'd100));
      // Reloading a live entry reports a hit and restarts it.
      send_item(load_req('0, 64'd1000, 32'd2, 64'd5000));
   endtask

   task automatic test_policing_cases();
      send_item(packet_req('0, 64'd100, 16'd100));   // first use, passes
      send_item(packet_req('0, 64'd150, 16'd500));   // tokens short of the cost
      send_item(packet_req('0, 64'd0, 16'd10));      // time goes back and stores zero
      send_item(packet_req('0, 64'd50, 16'd6000));   // first use again, allowance short
      send_item(packet_req('1, 64'd1, '1));          // allowance short on first use
      send_item(packet_req('1, 64'd2, 16'd100));     // refill saturates, huge cost passes
      send_item(packet_req('1, 64'd3, 16'd1));       // allowance used up
      send_item(packet_req('1, 64'd4, 16'd0));       // zero length still passes
      send_item(load_req(11'd5, '0, '0, '1));
      send_item(packet_req(11'd5, 64'd7, '1));       // zero rate, zero burst
      send_item(load_req(11'd1023, 64'h8000_0000_0000_0000, '1, '1));
      send_item(packet_req(11'd1023, '1, '1));
      send_item(packet_req(11'd1023, 64'd20, '1));   // elapsed wraps past the maximum
      send_item(packet_req(11'd1023, 64'd20, '1));   // no elapsed time, tokens drain
      send_item(packet_req(11'd1024, 64'd20, 16'd64)); // neighbor entry is still a miss
   endtask

   task automatic test_random_flows();
      flow_ids[0] = '0;
      flow_ids[1] = '1;
      for (int k = 2; k < FLOW_COUNT; k++) flow_ids[k] = IDX_W'($urandom_range(0, BUCKETS-1));
      for (int k = 0; k < FLOW_COUNT; k++)
         send_item(load_req(flow_ids[k], TIME_W'($urandom_range(0, 50000)),
                            RATE_W'($urandom_range(0, 20)),
                            TIME_W'($urandom_range(0, 400000))));
      for (int n = 0; n < 440; n++) begin
         tx_idle_en = (n < 150 || n >= 300);
         rx_idle_en = (n < 150 || n >= 300);
         send_item(flow_item());
      end
   endtask

   task automatic test_random_noise();
      policer_req_type r;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      for (int n = 0; n < 100; n++) begin
         r.func  = func_type'($urandom_range(0, 1));
         r.idx   = IDX_W'($urandom());
         r.now   = rand64();
         r.len   = LEN_W'($urandom());
         r.burst = rand64();
         r.rate  = $urandom();
         r.allow = rand64();
         send_item(r);
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering work.
   task automatic test_output_backpressure();
      tx_idle_en   = 1'b0;
      rx_idle_en   = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int n = 0; n < 40; n++) send_item(flow_item());
   endtask

   initial begin : receiver
      int n;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            n = idle_length();
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : verdict_checker
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: result with none expected, drop %0b hit %0b",
                     $time, rsp_drop, rsp_hit);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_drop !== want.drop) begin
               $display("%0t: drop expected %0b actual %0b", $time, want.drop, rsp_drop);
               mismatch_count++;
            end
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_hit);
               mismatch_count++;
            end
         end
      end
   end

   // The reset sweep of the table is the longest stretch without a transaction.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : main
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_misses_and_loads();
      test_policing_cases();
      test_random_flows();
      test_random_noise();
      test_output_backpressure();
      @(negedge clock);
      req_valid <= 1'b0;
      rx_idle_en = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/tbpt_pkg.sv
sv/tbpt_ram.sv
sv/tbpt_ctrl.sv
sv/tbpt_datapath.sv
sv/token_bucket_policer_table.sv
sim/token_bucket_policer_table_tb.sv
